>>> design/rfid_ascii_hex_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// rfid ascii hex frame parser assertion macros
// shared property wrappers for the frame parser checks
// ----------------------------------------------------------------------------
`ifndef RFID_ASCII_HEX_FRAME_PARSER_UNIT_ASSERT_SVH
`define RFID_ASCII_HEX_FRAME_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define RAHFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define RAHFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rahfp_pkg.sv
// ----------------------------------------------------------------------------
// rahfp_pkg
// shared types, byte codes and hex digit decode for the frame parser
// ----------------------------------------------------------------------------
package rahfp_pkg;

  localparam int ByteW = 8;
  localparam int TagW  = 40;
  localparam int PosW  = 4;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [TagW-1:0]  tag_t;
  typedef logic [PosW-1:0]  pos_t;

  localparam byte_t BYTE_STX = 8'h02;
  localparam byte_t BYTE_CR  = 8'h0D;
  localparam byte_t BYTE_LF  = 8'h0A;
  localparam byte_t BYTE_ETX = 8'h03;

  localparam pos_t POS_IDLE  = 4'd0;
  localparam pos_t POS_DIG0  = 4'd1;
  localparam pos_t POS_DIGN  = 4'd10;
  localparam pos_t POS_CR    = 4'd11;
  localparam pos_t POS_LF    = 4'd12;
  localparam pos_t POS_ETX   = 4'd13;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  // result handed from the deframer to the output register
  typedef struct packed {
    logic load;
    tag_t tag;
  } res_t;

  function automatic hex_t hex_decode(input byte_t b);
    hex_t  h;
    byte_t d;
    h = '0;
    d = '0;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      h.ok = 1'b1;
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      h.ok = 1'b1;
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
      h.ok = 1'b1;
    end
    h.nib = d[3:0];
    return h;
  endfunction

endpackage

>>> design/rfid_ascii_hex_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// rfid_ascii_hex_frame_parser_unit
// deframes STX / ten hex digits / CR LF ETX into a 40-bit tag identifier
// ----------------------------------------------------------------------------
// in_* carries one received serial byte per request in in_tdata[7:0].
// out_* carries one 40-bit tag identifier per complete frame, the first hex
// digit in the top nibble. bytes outside a frame, or a frame broken by a bad
// digit or terminator, give no result; the parser then waits for a new STX.
// throughput is one byte per cycle unless an ETX result waits on a stalled result
// register: the input register is emptied every cycle in which the deframer's
// position counter and shift register take its byte. after its ETX has passed
// the input register, an identifier is loaded into the result register, which
// drives out_tvalid. when the receiver stalls, the result register holds its
// identifier; bytes that give no result keep flowing, and only a second ETX
// result waits, which then backs up into in_tready.
// reset (rst_n low, synchronous) empties both registers, clears the shift
// register and puts the parser back to waiting for STX.
// ----------------------------------------------------------------------------
`include "rfid_ascii_hex_frame_parser_unit_assert.svh"

module rfid_ascii_hex_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [39:0] tag_id
);

  logic             byte_valid;
  rahfp_pkg::byte_t byte_q;
  logic             take;
  logic             out_free;
  rahfp_pkg::res_t  res;
  rahfp_pkg::pos_t  frame_pos;

  rahfp_byte_reg u_byte_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .valid_r   (byte_valid),
    .byte_r    (byte_q)
  );

  rahfp_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (byte_valid),
    .rx_byte   (byte_q),
    .out_free  (out_free),
    .take      (take),
    .res       (res),
    .frame_pos (frame_pos)
  );

  rahfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `RAHFP_ASSERT_SAME(a_ready_when_drained, clk, rst_n, out_tready, in_tready,
    "input stalled although the output is being drained")
  `RAHFP_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, res.load, out_tvalid,
    "loaded identifier did not show on the output")
  `RAHFP_ASSERT_SAME(a_pos_in_range, clk, rst_n, 1'b1,
    frame_pos <= rahfp_pkg::POS_ETX, "frame position beyond ETX slot")
  `RAHFP_ASSERT_SAME(a_rise_from_load, clk, rst_n, $rose(out_tvalid), $past(res.load),
    "output valid rose without a frame result")

endmodule

>>> design/rahfp_byte_reg.sv
// ----------------------------------------------------------------------------
// rahfp_byte_reg
// input register stage holding one received byte request
// ----------------------------------------------------------------------------
module rahfp_byte_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  rahfp_pkg::byte_t in_tdata,
  input  logic            take,
  output logic            valid_r,
  output rahfp_pkg::byte_t byte_r
);

  logic valid_nxt;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

>>> design/rahfp_deframer.sv
// ----------------------------------------------------------------------------
// rahfp_deframer
// frame position counter and identifier shift register
// ----------------------------------------------------------------------------
module rahfp_deframer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid,
  input  rahfp_pkg::byte_t rx_byte,
  input  logic             out_free,
  output logic             take,
  output rahfp_pkg::res_t  res,
  output rahfp_pkg::pos_t  frame_pos
);

  rahfp_pkg::pos_t pos_r, pos_nxt;
  rahfp_pkg::tag_t id_r, id_nxt;
  rahfp_pkg::hex_t hex;
  logic            emit;

  always_comb begin
    hex     = rahfp_pkg::hex_decode(rx_byte);
    pos_nxt = rahfp_pkg::POS_IDLE;
    id_nxt  = id_r;
    emit    = 1'b0;
    if (pos_r == rahfp_pkg::POS_IDLE) begin
      if (rx_byte == rahfp_pkg::BYTE_STX) begin
        pos_nxt = rahfp_pkg::POS_DIG0;
      end
    end else if (pos_r <= rahfp_pkg::POS_DIGN) begin
      if (hex.ok) begin
        id_nxt  = {id_r[rahfp_pkg::TagW-5:0], hex.nib};
        pos_nxt = pos_r + 4'd1;
      end
    end else if (pos_r == rahfp_pkg::POS_CR) begin
      if (rx_byte == rahfp_pkg::BYTE_CR) begin
        pos_nxt = rahfp_pkg::POS_LF;
      end
    end else if (pos_r == rahfp_pkg::POS_LF) begin
      if (rx_byte == rahfp_pkg::BYTE_LF) begin
        pos_nxt = rahfp_pkg::POS_ETX;
      end
    end else if (pos_r == rahfp_pkg::POS_ETX) begin
      emit = (rx_byte == rahfp_pkg::BYTE_ETX);
    end
  end

  // a byte that yields no result never waits on the output side
  assign take      = valid && (out_free || !emit);
  assign res       = '{load: take && emit, tag: id_r};
  assign frame_pos = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= rahfp_pkg::POS_IDLE;
      id_r  <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
      id_r  <= id_nxt;
    end
  end

endmodule

>>> design/rahfp_out_reg.sv
// ----------------------------------------------------------------------------
// rahfp_out_reg
// result register driving the tag identifier stream
// ----------------------------------------------------------------------------
module rahfp_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  rahfp_pkg::res_t res,
  output logic            out_free,
  output logic            out_tvalid,
  input  logic            out_tready,
  output rahfp_pkg::tag_t out_tdata
);

  logic            valid_r, valid_nxt;
  rahfp_pkg::tag_t tag_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = tag_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res.load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      tag_r <= res.tag;
    end
  end

endmodule

>>> tb/tb_rfid_ascii_hex_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rfid_ascii_hex_frame_parser_unit
// streams received bytes into the frame parser, rebuilds the STX / hex / CR LF
// ETX deframing on the side and checks every tag identifier that comes out
// ----------------------------------------------------------------------------
module tb_rfid_ascii_hex_frame_parser_unit;

  localparam int HoldOffCycles    = 150;
  localparam int DrainCycles      = 10;
  localparam int RandomFrameBytes = 700;
  localparam int CalmBytes        = 150;
  localparam int DigitBits        = 80;

  localparam logic [23:0] GoodTail =
    {rahfp_pkg::BYTE_CR, rahfp_pkg::BYTE_LF, rahfp_pkg::BYTE_ETX};

  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_TAG} row_kind_t;

  typedef struct {
    rahfp_pkg::byte_t     lead;
    logic [DigitBits-1:0] digs;
    logic [23:0]          tail;
    row_kind_t            kind;
    rahfp_pkg::tag_t      tag;
  } frame_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [39:0] tag_id

  rahfp_pkg::tag_t tag_q[$];
  int              errors = 0;
  int              hold_off_reqs = 0;
  bit              calm = 1'b0;

  // shadow of the deframer
  rahfp_pkg::pos_t frame_pos;
  rahfp_pkg::tag_t id_reg;

  frame_row_t directed_rows [16] = '{
    '{8'hFF, "FFFFFFFFFF", GoodTail, ROW_TAG, 40'hFF_FFFF_FFFF},
    '{8'h00, "0000000000", GoodTail, ROW_TAG, 40'h00_0000_0000},
    '{8'h03, "0123456789", GoodTail, ROW_TAG, 40'h01_2345_6789},
    '{8'h0D, "ABCDEFabcd", GoodTail, ROW_TAG, 40'hAB_CDEF_ABCD},
    '{8'h80, "fedcba9876", GoodTail, ROW_TAG, 40'hFE_DCBA_9876},
    // zero byte and STX inside the digits
    '{8'h0A, {"1234", 8'h00, "56789"}, GoodTail, ROW_NONE, 40'h0},
    '{8'h41, {"12", rahfp_pkg::BYTE_STX, "4567890"}, GoodTail, ROW_NONE, 40'h0},
    // just outside the hex ranges, on every side but above f
    '{8'h7F, "/123456789", GoodTail, ROW_NONE, 40'h0},
    '{8'h5A, "123456789:", GoodTail, ROW_NONE, 40'h0},
    '{8'h20, "1234@6789A", GoodTail, ROW_NONE, 40'h0},
    '{8'h66, "12345G7890", GoodTail, ROW_NONE, 40'h0},
    '{8'h31, "ab`defabcd", GoodTail, ROW_NONE, 40'h0},
    // bad terminators, the last one an STX in place of ETX
    '{8'h2A, "0123456789", {rahfp_pkg::BYTE_LF, rahfp_pkg::BYTE_LF, rahfp_pkg::BYTE_ETX},
      ROW_NONE, 40'h0},
    '{8'h2B, "0123456789", {rahfp_pkg::BYTE_CR, rahfp_pkg::BYTE_CR, rahfp_pkg::BYTE_ETX},
      ROW_NONE, 40'h0},
    '{8'h2C, "0123456789", {rahfp_pkg::BYTE_CR, rahfp_pkg::BYTE_LF, rahfp_pkg::BYTE_STX},
      ROW_NONE, 40'h0},
    // shift register still holds digits of the broken frames
    '{8'hFE, "9a8B7c6D5e", GoodTail, ROW_PRED, 40'h0}
  };

  rfid_ascii_hex_frame_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $error("timed out with %0d tags outstanding", tag_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit is_hex_char(input rahfp_pkg::byte_t b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
  endfunction

  // one byte through the shadow deframer
  function automatic void deframe(input rahfp_pkg::byte_t b, output bit got,
                                  output rahfp_pkg::tag_t tag);
    logic [3:0] nib;
    got = 1'b0;
    tag = '0;
    // letters have 1..6 in the low nibble
    nib = (b <= "9") ? b[3:0] : b[3:0] + 4'd9;
    if (frame_pos == rahfp_pkg::POS_IDLE) begin
      if (b == rahfp_pkg::BYTE_STX) frame_pos = rahfp_pkg::POS_DIG0;
    end else if (frame_pos <= rahfp_pkg::POS_DIGN) begin
      if (is_hex_char(b)) begin
        id_reg    = {id_reg[rahfp_pkg::TagW-5:0], nib};
        frame_pos = frame_pos + 4'd1;
      end else begin
        frame_pos = rahfp_pkg::POS_IDLE;
      end
    end else if (frame_pos == rahfp_pkg::POS_CR) begin
      frame_pos = (b == rahfp_pkg::BYTE_CR) ? rahfp_pkg::POS_LF : rahfp_pkg::POS_IDLE;
    end else if (frame_pos == rahfp_pkg::POS_LF) begin
      frame_pos = (b == rahfp_pkg::BYTE_LF) ? rahfp_pkg::POS_ETX : rahfp_pkg::POS_IDLE;
    end else begin
      got       = (frame_pos == rahfp_pkg::POS_ETX) && (b == rahfp_pkg::BYTE_ETX);
      tag       = id_reg;
      frame_pos = rahfp_pkg::POS_IDLE;
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input rahfp_pkg::byte_t b, input bit by_model,
                           input bit typed_hit, input rahfp_pkg::tag_t typed);
    bit              got;
    rahfp_pkg::tag_t tag;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (in_tready !== 1'b1);
    deframe(b, got, tag);
    if (by_model && got) tag_q.push_back(tag);
    if (typed_hit) tag_q.push_back(typed);
    @(negedge clk);
  endtask

  task automatic send_random_frame(input bit well_formed);
    rahfp_pkg::byte_t seq [14];
    logic [3:0]       nib;
    int               flaw_at;
    rahfp_pkg::byte_t bad;
    seq[0] = rahfp_pkg::BYTE_STX;
    for (int i = 1; i <= 10; i++) begin
      nib = 4'($urandom_range(0, 15));
      if (nib < 4'd10) seq[i] = 8'h30 + 8'(nib);
      else seq[i] = ($urandom_range(0, 1) ? 8'h60 : 8'h40) + 8'(nib) - 8'd9;
    end
    seq[11] = rahfp_pkg::BYTE_CR;
    seq[12] = rahfp_pkg::BYTE_LF;
    seq[13] = rahfp_pkg::BYTE_ETX;
    if (!well_formed) begin
      flaw_at = $urandom_range(1, 13);
      if ($urandom_range(0, 3) == 0) begin
        bad = rahfp_pkg::BYTE_STX;
      end else begin
        do bad = 8'($urandom_range(0, 255));
        while (flaw_at <= 10 ? is_hex_char(bad) : bad == seq[flaw_at]);
      end
      seq[flaw_at] = bad;
    end
    foreach (seq[i]) send_byte(seq[i], 1'b1, 1'b0, '0);
  endtask

  // receiver side
  initial begin
    int seen;
    out_tready = 1'b0;
    seen = 0;
    @(negedge clk);
    forever begin
      if (seen != hold_off_reqs) begin
        seen++;
        out_tready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : tag_check
    rahfp_pkg::tag_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (tag_q.size() == 0) begin
        $error("tag_id: no result expected, actual %h", out_tdata);
        errors++;
      end else begin
        want = tag_q.pop_front();
        if (out_tdata !== want) begin
          $error("tag_id: expected %h, actual %h", want, out_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    frame_row_t row;
    bit         by_model;
    int         sent;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    frame_pos = rahfp_pkg::POS_IDLE;
    id_reg    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      row      = directed_rows[r];
      by_model = (row.kind == ROW_PRED);
      send_byte(row.lead, by_model, 1'b0, '0);
      send_byte(rahfp_pkg::BYTE_STX, by_model, 1'b0, '0);
      for (int i = 0; i < 10; i++)
        send_byte(row.digs[DigitBits-1-8*i -: 8], by_model, 1'b0, '0);
      for (int i = 0; i < 3; i++)
        send_byte(row.tail[23-8*i -: 8], by_model, row.kind == ROW_TAG && i == 2, row.tag);
    end

    // let everything drain, then back-to-back frames into a stalled receiver
    in_tvalid = 1'b0;
    while (tag_q.size() != 0) @(negedge clk);
    hold_off_reqs++;
    calm = 1'b1;
    repeat (5) send_random_frame(1'b1);
    calm = 1'b0;

    sent = 0;
    while (sent < RandomFrameBytes) begin
      if (sent >= RandomFrameBytes - CalmBytes) calm = 1'b1;
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      send_random_frame($urandom_range(0, 9) < 7);
      sent += 14;
    end

    in_tvalid = 1'b0;
    while (tag_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/rahfp_pkg.sv
design/rahfp_byte_reg.sv
design/rahfp_deframer.sv
design/rahfp_out_reg.sv
design/rfid_ascii_hex_frame_parser_unit.sv
tb/tb_rfid_ascii_hex_frame_parser_unit.sv
